[rtl/core/mgoc_pkg.sv]
// shared constants and types for the gram orthogonality check
package mgoc_pkg;

    localparam int ORDER_DEFAULT = 4;
    localparam int ORDER_MAX     = 8;
    localparam int ELEM_W        = 16;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int ACC_W         = 40;
    localparam int IDX_W         = 3;

    // control that travels beside one product term through the mac
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

[rtl/core/mgoc_mac.sv]
// shared multiply-accumulate unit for the dot products of the gram matrix
module mgoc_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mgoc_pkg::mac_ctl_t                   ctl,
    input  logic signed [mgoc_pkg::ELEM_W-1:0]   op_a,
    input  logic signed [mgoc_pkg::ELEM_W-1:0]   op_b,
    input  logic                                 done_clear,
    output logic signed [mgoc_pkg::ACC_W-1:0]    acc,
    output logic                                 done
);
    import mgoc_pkg::*;

    mac_ctl_t                  prod_ctl_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      done_reg;
    logic                      done_next;

    // product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
        end
        else
        begin
            prod_ctl_reg <= ctl;
        end
    end

    // accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (prod_ctl_reg.valid)
        begin
            if (prod_ctl_reg.first)
            begin
                acc_next = ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (done_clear)
        begin
            done_next = 1'b0;
        end
        if (prod_ctl_reg.valid && prod_ctl_reg.last)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

[rtl/core/matrix_gram_orthogonality_check_unit.sv]
// top level: loads a square matrix, streams out A times A transpose and an identity flag
// loading takes ORDER*ORDER elements; the first product element follows once the last one is in
// products come out one at a time from the single shared mac, which walks the ORDER terms
//   of each dot product through the registered memory reads; a stalled output holds it
// no new matrix element is taken until every product element of the current one is emitted
// reset: asynchronous, active low; clears the load count, state and valid flags, not the memory
module matrix_gram_orthogonality_check_unit #(
    parameter int ORDER = mgoc_pkg::ORDER_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [mgoc_pkg::ELEM_W-1:0]  element,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mgoc_pkg::ACC_W-1:0]   product_value,
    output logic [mgoc_pkg::IDX_W-1:0]          row_index,
    output logic [mgoc_pkg::IDX_W-1:0]          col_index,
    output logic                                is_orthogonal,
    output logic                                last_result
);
    import mgoc_pkg::*;

    localparam int CELLS = ORDER * ORDER;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int KW    = (ORDER > 1) ? $clog2(ORDER) : 1;

    // one-hot controller states
    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,   // taking matrix elements
        ST_ISSUE = 4'b0010,   // one memory read pair per dot product term
        ST_DRAIN = 4'b0100,   // wait for the mac to finish the sum
        ST_EMIT  = 4'b1000    // move the sum into the output register
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       load_cnt_reg, load_cnt_next;
    logic [KW-1:0]       row_reg, row_next;
    logic [KW-1:0]       col_reg, col_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                ident_reg, ident_next;

    // matrix memory, one write port and two registered read ports
    logic signed [ELEM_W-1:0] mem [CELLS];
    logic signed [ELEM_W-1:0] rd_a_reg;
    logic signed [ELEM_W-1:0] rd_b_reg;
    logic [AW-1:0]            rd_a_addr;
    logic [AW-1:0]            rd_b_addr;
    logic                     wr_en;

    mac_ctl_t                 rd_ctl_reg, rd_ctl_next;

    logic signed [ACC_W-1:0]  acc;
    logic                     mac_done;
    logic                     emit_fire;
    logic                     entry_match;
    logic                     entry_last;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]  value_reg;
    logic [IDX_W-1:0]         row_out_reg;
    logic [IDX_W-1:0]         col_out_reg;
    logic                     orth_reg;
    logic                     last_reg;

    assign in_ready = (state_reg == ST_LOAD);
    assign wr_en    = in_valid && in_ready;

    // row r term k and row c term k of the stored matrix
    assign rd_a_addr = AW'(int'(row_reg) * ORDER + int'(k_reg));
    assign rd_b_addr = AW'(int'(col_reg) * ORDER + int'(k_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[load_cnt_reg] <= element;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    // the read data is registered and comes in the cycle after the address, so its tag does too
    always_comb
    begin
        rd_ctl_next.valid = (state_reg == ST_ISSUE);
        rd_ctl_next.first = (k_reg == '0);
        rd_ctl_next.last  = (k_reg == KW'(ORDER - 1));
    end

    mgoc_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rd_ctl_reg),
        .op_a       (rd_a_reg),
        .op_b       (rd_b_reg),
        .done_clear (emit_fire),
        .acc        (acc),
        .done       (mac_done)
    );

    // the output register is free when empty or being drained this cycle
    assign emit_fire   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign entry_match = (row_reg == col_reg) ? (acc == ACC_W'(1)) : (acc == '0);
    assign entry_last  = (row_reg == KW'(ORDER - 1)) && (col_reg == KW'(ORDER - 1));

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        ident_next    = ident_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (wr_en)
                begin
                    if (load_cnt_reg == AW'(CELLS - 1))
                    begin
                        load_cnt_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                        k_next        = '0;
                        ident_next    = 1'b1;
                        state_next    = ST_ISSUE;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + AW'(1);
                    end
                end
            end
            ST_ISSUE:
            begin
                if (k_reg == KW'(ORDER - 1))
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    ident_next = ident_reg && entry_match;
                    if (entry_last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (col_reg == KW'(ORDER - 1))
                        begin
                            col_next = '0;
                            row_next = row_reg + KW'(1);
                        end
                        else
                        begin
                            col_next = col_reg + KW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            ident_reg     <= 1'b1;
            rd_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            k_reg         <= k_next;
            ident_reg     <= ident_next;
            rd_ctl_reg    <= rd_ctl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, the identity flag only shows on the final element
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            value_reg   <= acc;
            row_out_reg <= IDX_W'(row_reg);
            col_out_reg <= IDX_W'(col_reg);
            orth_reg    <= entry_last && ident_reg && entry_match;
            last_reg    <= entry_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_value = value_reg;
    assign row_index     = row_out_reg;
    assign col_index     = col_out_reg;
    assign is_orthogonal = orth_reg;
    assign last_result   = last_reg;

endmodule

[test/matrix_gram_orthogonality_check_unit_tb.sv]
// testbench for the gram orthogonality check: matrix streams in, A times A transpose checked out
module matrix_gram_orthogonality_check_unit_tb;

    import mgoc_pkg::*;

    localparam int MAT_ORDER = mgoc_pkg::ORDER_DEFAULT;
    localparam int CELLS     = MAT_ORDER * MAT_ORDER;
    localparam int MAX_IDLE  = 6;
    // settle time scaled from CELLS and MAT_ORDER
    localparam int SETTLE_CYCLES = 4 * CELLS * (MAT_ORDER + 5);

    // kinds of matrix the random part draws
    typedef enum int {
        MAT_SIGNED_PERM,
        MAT_NEAR_MISS,
        MAT_EXTREME,
        MAT_FULL_RANDOM,
        MAT_SMALL
    } matrix_kind_t;

    // one predicted product element
    typedef struct {
        logic signed [ACC_W-1:0] product;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    orth;
        logic                    last;
    } gram_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [ELEM_W-1:0]   element;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [ACC_W-1:0]    product_value;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           col_index;
    logic                       is_orthogonal;
    logic                       last_result;

    // predictor state: elements of the matrix being loaded
    logic signed [ELEM_W-1:0]   loaded [CELLS];
    int                         loaded_count;
    // products predicted but not yet seen at the output
    gram_result_t               products_due [$];
    // matrix prepared by a test before it is streamed in
    logic signed [ELEM_W-1:0]   staged [CELLS];

    int                         failures;
    bit                         no_idle;

    matrix_gram_orthogonality_check_unit #(
        .ORDER(MAT_ORDER)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element       (element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .product_value (product_value),
        .row_index     (row_index),
        .col_index     (col_index),
        .is_orthogonal (is_orthogonal),
        .last_result   (last_result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // idle cycles for one transfer; zero during stretches without idling
    function automatic int draw_idle();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // full product once the last element is in, row-major, identity flag on the last one
    function automatic void compute_gram();
        gram_result_t res;
        longint       acc;
        bit           ident;
        int           r, c, k;
        ident = 1'b1;
        for (r = 0; r < MAT_ORDER; r++)
        begin
            for (c = 0; c < MAT_ORDER; c++)
            begin
                acc = 0;
                for (k = 0; k < MAT_ORDER; k++)
                    acc += longint'(loaded[r * MAT_ORDER + k])
                         * longint'(loaded[c * MAT_ORDER + k]);
                if (acc != ((r == c) ? 1 : 0))
                    ident = 1'b0;
                res.product = acc[ACC_W-1:0];
                res.row     = IDX_W'(r);
                res.col     = IDX_W'(c);
                res.last    = (r == MAT_ORDER - 1) && (c == MAT_ORDER - 1);
                res.orth    = res.last && ident;
                products_due.push_back(res);
            end
        end
    endfunction

    function automatic void absorb_element(input logic signed [ELEM_W-1:0] value);
        loaded[loaded_count] = value;
        loaded_count++;
        if (loaded_count == CELLS)
        begin
            compute_gram();
            loaded_count = 0;
        end
    endfunction

    // one input transfer; valid stays high into the next call when no gap is drawn
    task automatic send_element(input logic signed [ELEM_W-1:0] value);
        int gap;
        in_valid <= 1'b1;
        element  <= value;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        absorb_element(value);
        gap = draw_idle();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_staged(input int first, input int count);
        int i;
        for (i = first; i < first + count; i++)
            send_element(staged[i]);
    endtask

    // sender goes quiet until every predicted product has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (products_due.size() != 0);
    endtask

    function automatic void stage_signed_perm();
        int perm [MAT_ORDER];
        int i, j, t;
        for (i = 0; i < MAT_ORDER; i++)
            perm[i] = i;
        for (i = MAT_ORDER - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i < CELLS; i++)
            staged[i] = '0;
        for (i = 0; i < MAT_ORDER; i++)
            staged[i * MAT_ORDER + perm[i]] = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
    endfunction

    function automatic void stage_matrix(input matrix_kind_t kind);
        int i, idx;
        case (kind)
            MAT_SIGNED_PERM:
                stage_signed_perm();
            MAT_NEAR_MISS:
            begin
                // any single step of one entry breaks orthogonality
                stage_signed_perm();
                idx = $urandom_range(0, CELLS - 1);
                if (staged[idx] == 0)
                    staged[idx] = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
                else
                    staged[idx] = $urandom_range(0, 1) ? 16'sd0 : staged[idx] * 16'sd2;
            end
            MAT_EXTREME:
                for (i = 0; i < CELLS; i++)
                    case ($urandom_range(0, 4))
                        0: staged[i] = -16'sd32768;
                        1: staged[i] = 16'sd32767;
                        2: staged[i] = 16'sd0;
                        3: staged[i] = -16'sd1;
                        default: staged[i] = 16'sd1;
                    endcase
            MAT_FULL_RANDOM:
                for (i = 0; i < CELLS; i++)
                    staged[i] = ELEM_W'($urandom_range(0, 65535));
            default:
                for (i = 0; i < CELLS; i++)
                    staged[i] = ELEM_W'($urandom_range(0, 4)) - 16'sd2;
        endcase
    endfunction

    // anti-diagonal with mixed signs: orthogonal, flag must be set
    task automatic test_orthogonal();
        int r;
        for (r = 0; r < CELLS; r++)
            staged[r] = '0;
        for (r = 0; r < MAT_ORDER; r++)
            staged[r * MAT_ORDER + (MAT_ORDER - 1 - r)] = (r % 2) ? -16'sd1 : 16'sd1;
        send_staged(0, CELLS);
    endtask

    // largest magnitudes: rows of most negative, most positive, alternating, mixed
    task automatic test_extremes();
        int i;
        for (i = 0; i < CELLS; i++)
            case ((i / MAT_ORDER) % 4)
                0: staged[i] = -16'sd32768;
                1: staged[i] = 16'sd32767;
                2: staged[i] = (i % 2) ? 16'sd32767 : -16'sd32768;
                default:
                    case (i % 4)
                        0: staged[i] = 16'sd0;
                        1: staged[i] = -16'sd1;
                        2: staged[i] = 16'sd1;
                        default: staged[i] = 16'sd32767;
                    endcase
            endcase
        send_staged(0, CELLS);
    endtask

    // sender stops mid-load and after the matrix until the output side is empty
    task automatic test_drain_pause();
        stage_matrix(MAT_FULL_RANDOM);
        send_staged(0, 5);
        hold_until_drained();
        send_staged(5, CELLS - 5);
        hold_until_drained();
    endtask

    task automatic test_random(input int matrices);
        int m;
        for (m = 0; m < matrices; m++)
        begin
            // every kind comes round, every fourth matrix runs without idling
            no_idle = (m % 4 == 3);
            stage_matrix(matrix_kind_t'(m % 5));
            send_staged(0, CELLS);
            if ($urandom_range(0, 3) == 0)
                hold_until_drained();
        end
        no_idle = 1'b0;
    endtask

    // output side: random stall before each result transfer
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_idle();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // compare every result transfer against the oldest prediction
    always @(posedge clk)
    begin
        gram_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (products_due.size() == 0)
            begin
                $error("unexpected product row %0d col %0d value %0d",
                       row_index, col_index, product_value);
                failures++;
            end
            else
            begin
                want = products_due.pop_front();
                if (product_value !== want.product)
                begin
                    $error("product_value expected %0d actual %0d", want.product, product_value);
                    failures++;
                end
                if (row_index !== want.row)
                begin
                    $error("row_index expected %0d actual %0d", want.row, row_index);
                    failures++;
                end
                if (col_index !== want.col)
                begin
                    $error("col_index expected %0d actual %0d", want.col, col_index);
                    failures++;
                end
                if (is_orthogonal !== want.orth)
                begin
                    $error("is_orthogonal expected %0b actual %0b", want.orth, is_orthogonal);
                    failures++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result expected %0b actual %0b", want.last, last_result);
                    failures++;
                end
            end
        end
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        element      = '0;
        failures     = 0;
        no_idle      = 1'b0;
        loaded_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_orthogonal();
        test_extremes();
        test_drain_pause();
        test_random(10);

        // all stimulus is in: wait for the last products, then watch for strays
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && products_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[matrix_gram_orthogonality_check_unit.f]
rtl/core/mgoc_pkg.sv
rtl/core/mgoc_mac.sv
rtl/core/matrix_gram_orthogonality_check_unit.sv
test/matrix_gram_orthogonality_check_unit_tb.sv
